FILE: hw/rtl/rcpa_pkg.sv
// Shared constants, codes and control types for the color pair allocator.
`timescale 1ns / 1ps

package rcpa_pkg;

	// Table geometry
	localparam int MAX_PAIRS   = 256;
	localparam int FIRST_INDEX = 16;
	localparam int COLOR_BITS  = 25;
	localparam int SLOTS       = MAX_PAIRS - FIRST_INDEX;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int USED_W      = $clog2(SLOTS + 1);

	// Field widths
	localparam int IDX_W   = 8;
	localparam int STAT_W  = 3;
	localparam int REF_W   = 16;
	localparam int LIMIT_W = 9;

	localparam logic [REF_W-1:0]   REF_MAX     = {REF_W{1'b1}};
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

	// Commands
	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_NEW          = 3'd0;
	localparam logic [STAT_W-1:0] STAT_SHARED       = 3'd1;
	localparam logic [STAT_W-1:0] STAT_BOTH_DEFAULT = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL         = 3'd3;
	localparam logic [STAT_W-1:0] STAT_STILL_USED   = 3'd4;
	localparam logic [STAT_W-1:0] STAT_FREED        = 3'd5;
	localparam logic [STAT_W-1:0] STAT_IGNORED      = 3'd6;

	// One table entry as held in the entry RAM
	typedef struct packed {
		logic [COLOR_BITS-1:0] fg;
		logic [COLOR_BITS-1:0] bg;
		logic [REF_W-1:0]      refs;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic rd_rel;
		logic scan_step;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_release;
		logic both_default;
		logic rel_absent;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

FILE: hw/rtl/refcounted_color_pair_allocator.sv
// Top level of the reference-counted color pair allocator.
// Acquire of a non-default pair: the result waits for a scan of
// all 240 entries through the single read port of the entry RAM, one entry per cycle.
// Release and acquire of both default colors go straight to commit without a scan.
// One item at a time: the next item is accepted the cycle after the result is committed,
// and the commit waits while the output is stalled.
`timescale 1ns / 1ps

module refcounted_color_pair_allocator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   command,
	input  logic signed [rcpa_pkg::COLOR_BITS-1:0] fg_color,
	input  logic signed [rcpa_pkg::COLOR_BITS-1:0] bg_color,
	input  logic [rcpa_pkg::IDX_W-1:0]             pair_index,
	input  logic                                   cfg_wr_en,
	input  logic [rcpa_pkg::LIMIT_W-1:0]           cfg_wr_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [rcpa_pkg::IDX_W-1:0]             result_index,
	output logic [rcpa_pkg::STAT_W-1:0]            status,
	output logic [rcpa_pkg::REF_W-1:0]             ref_count_out,
	output logic                                   first_overflow,
	output logic [rcpa_pkg::IDX_W-1:0]             pairs_in_use
);

	rcpa_pkg::ctrl_cmd_t  cmd;
	rcpa_pkg::dp_status_t stat;

	rcpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	rcpa_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.command        (command),
		.fg_color       (fg_color),
		.bg_color       (bg_color),
		.pair_index     (pair_index),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_index   (result_index),
		.status         (status),
		.ref_count_out  (ref_count_out),
		.first_overflow (first_overflow),
		.pairs_in_use   (pairs_in_use),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule

FILE: hw/rtl/rcpa_entry_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rcpa_entry_ram #(
	parameter int DEPTH = 240,
	parameter int WIDTH = 66,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/rcpa_datapath.sv
// Datapath: item registers, entry table, scan compare, result and output register.
`timescale 1ns / 1ps

module rcpa_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  command,
	input  logic signed [rcpa_pkg::COLOR_BITS-1:0] fg_color,
	input  logic signed [rcpa_pkg::COLOR_BITS-1:0] bg_color,
	input  logic [rcpa_pkg::IDX_W-1:0]            pair_index,
	input  logic                                  cfg_wr_en,
	input  logic [rcpa_pkg::LIMIT_W-1:0]          cfg_wr_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [rcpa_pkg::IDX_W-1:0]            result_index,
	output logic [rcpa_pkg::STAT_W-1:0]           status,
	output logic [rcpa_pkg::REF_W-1:0]            ref_count_out,
	output logic                                  first_overflow,
	output logic [rcpa_pkg::IDX_W-1:0]            pairs_in_use,
	input  rcpa_pkg::ctrl_cmd_t                   cmd,
	output rcpa_pkg::dp_status_t                  stat
);

	// Captured item
	logic                            cmd_q;
	logic [rcpa_pkg::COLOR_BITS-1:0] fg_q;
	logic [rcpa_pkg::COLOR_BITS-1:0] bg_q;
	logic [rcpa_pkg::IDX_W-1:0]      idx_q;

	// Configuration and global state
	logic [rcpa_pkg::LIMIT_W-1:0] limit_q;
	logic [rcpa_pkg::SLOTS-1:0]   valid_q;
	logic [rcpa_pkg::USED_W-1:0]  used_q;
	logic                         warned_q;

	// Scan state
	logic [rcpa_pkg::SLOT_W-1:0] scan_q;
	logic [rcpa_pkg::SLOT_W-1:0] rd_slot_s1;
	logic                        rd_vld_s1;
	logic                        hit_q;
	logic [rcpa_pkg::SLOT_W-1:0] hit_slot_q;
	logic [rcpa_pkg::REF_W-1:0]  hit_refs_q;
	logic                        free_q;
	logic [rcpa_pkg::SLOT_W-1:0] free_slot_q;

	// Output register
	logic                          out_valid_q;
	logic [rcpa_pkg::IDX_W-1:0]    res_idx_q;
	logic [rcpa_pkg::STAT_W-1:0]   res_stat_q;
	logic [rcpa_pkg::REF_W-1:0]    res_refs_q;
	logic                          res_ovf_q;
	logic [rcpa_pkg::IDX_W-1:0]    res_used_q;

	// RAM signals
	logic                          ram_wr_en;
	logic [rcpa_pkg::SLOT_W-1:0]   ram_wr_addr;
	rcpa_pkg::entry_t              ram_wr_entry;
	logic                          ram_rd_en;
	logic [rcpa_pkg::SLOT_W-1:0]   ram_rd_addr;
	logic [rcpa_pkg::ENTRY_W-1:0]  ram_rd_data;
	rcpa_pkg::entry_t              rd_entry;

	// Decode and result
	logic                          both_default;
	logic                          rel_in_range;
	logic [rcpa_pkg::SLOT_W-1:0]   rel_slot;
	logic                          rel_absent;
	logic                          cur_match;
	logic                          cur_free;
	logic                          fits;
	logic [rcpa_pkg::REF_W-1:0]    sat_refs;
	logic [rcpa_pkg::REF_W-1:0]    dec_refs;
	logic                          out_free;

	logic [rcpa_pkg::IDX_W-1:0]    res_idx;
	logic [rcpa_pkg::STAT_W-1:0]   res_stat;
	logic [rcpa_pkg::REF_W-1:0]    res_refs;
	logic                          res_ovf;
	logic                          set_valid;
	logic                          clr_valid;
	logic [rcpa_pkg::SLOT_W-1:0]   v_slot;
	logic                          used_inc;
	logic                          used_dec;
	logic                          warn_set;
	logic [rcpa_pkg::USED_W-1:0]   used_nxt;

	rcpa_entry_ram #(
		.DEPTH (rcpa_pkg::SLOTS),
		.WIDTH (rcpa_pkg::ENTRY_W),
		.AW    (rcpa_pkg::SLOT_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_entry),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign rd_entry = rcpa_pkg::entry_t'(ram_rd_data);

	// Decode the captured item
	assign both_default = (&fg_q) && (&bg_q);
	assign rel_in_range = (idx_q >= rcpa_pkg::IDX_W'(rcpa_pkg::FIRST_INDEX))
		&& (int'(idx_q) < rcpa_pkg::MAX_PAIRS);
	assign rel_slot     = rcpa_pkg::SLOT_W'(idx_q - rcpa_pkg::IDX_W'(rcpa_pkg::FIRST_INDEX));
	assign rel_absent   = !(rel_in_range && valid_q[rel_slot]);

	// Read address: release lookup or scan pointer
	assign ram_rd_en   = cmd.rd_rel | cmd.scan_step;
	assign ram_rd_addr = cmd.rd_rel ? rel_slot : scan_q;

	// Compare the entry read in the previous cycle
	assign cur_match = rd_vld_s1 && valid_q[rd_slot_s1]
		&& (rd_entry.fg == fg_q) && (rd_entry.bg == bg_q);
	assign cur_free  = rd_vld_s1 && !valid_q[rd_slot_s1];

	assign fits     = free_q
		&& ((int'(free_slot_q) + rcpa_pkg::FIRST_INDEX) < int'(limit_q));
	assign sat_refs = (hit_refs_q == rcpa_pkg::REF_MAX) ? hit_refs_q : hit_refs_q + 1'b1;
	assign dec_refs = (rd_entry.refs != '0) ? rd_entry.refs - 1'b1 : '0;
	assign out_free = !out_valid_q || !out_stall;

	// Work out the result and the table update
	always_comb begin
		res_idx      = '0;
		res_stat     = rcpa_pkg::STAT_IGNORED;
		res_refs     = '0;
		res_ovf      = 1'b0;
		ram_wr_en    = 1'b0;
		ram_wr_addr  = hit_slot_q;
		ram_wr_entry = '{fg: fg_q, bg: bg_q, refs: sat_refs};
		set_valid    = 1'b0;
		clr_valid    = 1'b0;
		v_slot       = free_slot_q;
		used_inc     = 1'b0;
		used_dec     = 1'b0;
		warn_set     = 1'b0;
		if (cmd_q == rcpa_pkg::CMD_ACQUIRE) begin
			if (both_default) begin
				res_stat = rcpa_pkg::STAT_BOTH_DEFAULT;
			end else if (hit_q) begin
				res_idx   = rcpa_pkg::IDX_W'(hit_slot_q)
					+ rcpa_pkg::IDX_W'(rcpa_pkg::FIRST_INDEX);
				res_stat  = rcpa_pkg::STAT_SHARED;
				res_refs  = sat_refs;
				ram_wr_en = cmd.commit;
			end else if (fits) begin
				res_idx      = rcpa_pkg::IDX_W'(free_slot_q)
					+ rcpa_pkg::IDX_W'(rcpa_pkg::FIRST_INDEX);
				res_stat     = rcpa_pkg::STAT_NEW;
				res_refs     = rcpa_pkg::REF_W'(1);
				ram_wr_en    = cmd.commit;
				ram_wr_addr  = free_slot_q;
				ram_wr_entry = '{fg: fg_q, bg: bg_q, refs: rcpa_pkg::REF_W'(1)};
				set_valid    = 1'b1;
				used_inc     = 1'b1;
			end else begin
				res_stat = rcpa_pkg::STAT_FULL;
				res_ovf  = (limit_q != '0) && !warned_q;
				warn_set = res_ovf;
			end
		end else begin
			if (rel_absent) begin
				res_stat = rcpa_pkg::STAT_IGNORED;
			end else if (dec_refs != '0) begin
				res_idx      = idx_q;
				res_stat     = rcpa_pkg::STAT_STILL_USED;
				res_refs     = dec_refs;
				ram_wr_en    = cmd.commit;
				ram_wr_addr  = rel_slot;
				ram_wr_entry = '{fg: rd_entry.fg, bg: rd_entry.bg, refs: dec_refs};
			end else begin
				res_idx   = idx_q;
				res_stat  = rcpa_pkg::STAT_FREED;
				clr_valid = 1'b1;
				v_slot    = rel_slot;
				used_dec  = (used_q != '0);
			end
		end
	end

	always_comb begin
		used_nxt = used_q;
		if (used_inc) begin
			used_nxt = used_q + 1'b1;
		end else if (used_dec) begin
			used_nxt = used_q - 1'b1;
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			fg_q  <= $unsigned(fg_color);
			bg_q  <= $unsigned(bg_color);
			idx_q <= pair_index;
		end
	end

	// Scan pointer and compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			scan_q    <= '0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.load) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					scan_q <= scan_q + 1'b1;
				end
				if (cur_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (cur_free && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			rd_slot_s1 <= scan_q;
		end
		if (cur_match && !hit_q) begin
			hit_slot_q <= rd_slot_s1;
			hit_refs_q <= rd_entry.refs;
		end
		if (cur_free && !free_q) begin
			free_slot_q <= rd_slot_s1;
		end
	end

	// Configuration, valid bits and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= rcpa_pkg::LIMIT_RESET;
			valid_q  <= '0;
			used_q   <= '0;
			warned_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (cmd.commit) begin
				used_q <= used_nxt;
				if (set_valid) begin
					valid_q[v_slot] <= 1'b1;
				end
				if (clr_valid) begin
					valid_q[v_slot] <= 1'b0;
				end
				if (warn_set) begin
					warned_q <= 1'b1;
				end
			end
		end
	end

	// Output register: load on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_idx_q  <= res_idx;
			res_stat_q <= res_stat;
			res_refs_q <= res_refs;
			res_ovf_q  <= res_ovf;
			res_used_q <= rcpa_pkg::IDX_W'(used_nxt);
		end
	end

	assign out_valid      = out_valid_q;
	assign result_index   = res_idx_q;
	assign status         = res_stat_q;
	assign ref_count_out  = res_refs_q;
	assign first_overflow = res_ovf_q;
	assign pairs_in_use   = res_used_q;

	// Status to the controller
	assign stat.is_release   = (cmd_q == rcpa_pkg::CMD_RELEASE);
	assign stat.both_default = both_default;
	assign stat.rel_absent   = rel_absent;
	assign stat.scan_last    = (scan_q == rcpa_pkg::SLOT_W'(rcpa_pkg::SLOTS - 1));
	assign stat.out_free     = out_free;

endmodule

FILE: hw/rtl/rcpa_ctrl.sv
// Controller state machine: item intake, table scan, release lookup, commit.
`timescale 1ns / 1ps

module rcpa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rcpa_pkg::dp_status_t stat,
	output rcpa_pkg::ctrl_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_SCAN     = 3'd2;
	localparam logic [2:0] S_DRAIN    = 3'd3;
	localparam logic [2:0] S_FIN      = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.is_release) begin
					cmd.rd_rel = !stat.rel_absent;
					state_nxt  = S_FIN;
				end else if (stat.both_default) begin
					state_nxt = S_FIN;
				end else begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

FILE: hw/rtl/rcpa_checker.sv
// Port-level checks for the color pair allocator, bound to the top level.
`timescale 1ns / 1ps

module rcpa_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_stall,
	input logic                                   command,
	input logic signed [rcpa_pkg::COLOR_BITS-1:0] fg_color,
	input logic signed [rcpa_pkg::COLOR_BITS-1:0] bg_color,
	input logic [rcpa_pkg::IDX_W-1:0]             pair_index,
	input logic                                   cfg_wr_en,
	input logic [rcpa_pkg::LIMIT_W-1:0]           cfg_wr_data,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic [rcpa_pkg::IDX_W-1:0]             result_index,
	input logic [rcpa_pkg::STAT_W-1:0]            status,
	input logic [rcpa_pkg::REF_W-1:0]             ref_count_out,
	input logic                                   first_overflow,
	input logic [rcpa_pkg::IDX_W-1:0]             pairs_in_use
);

	// Hold a stalled item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_index))
		else $error("stalled result changed or dropped");

	// No pair index or count on refusals
	a_no_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rcpa_pkg::STAT_BOTH_DEFAULT || status == rcpa_pkg::STAT_FULL
			|| status == rcpa_pkg::STAT_IGNORED)
		|-> result_index == '0 && ref_count_out == '0)
		else $error("refusal carries an index or count");

	// New entries start at one reference at a table index
	a_new_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rcpa_pkg::STAT_NEW
		|-> ref_count_out == rcpa_pkg::REF_W'(1)
			&& result_index >= rcpa_pkg::IDX_W'(rcpa_pkg::FIRST_INDEX)
			&& pairs_in_use != '0)
		else $error("bad new entry result");

	// Overflow flag only on a full refusal
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_overflow |-> status == rcpa_pkg::STAT_FULL)
		else $error("overflow flag outside a full refusal");

endmodule

bind refcounted_color_pair_allocator rcpa_checker u_rcpa_checker (.*);

FILE: verif/color_pair_checker.sv
// Watches both channels of the color pair allocator, predicts every result and compares.
`timescale 1ns / 1ps

module color_pair_checker
	import rcpa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  command,
	input  logic [COLOR_BITS-1:0] fg_color,
	input  logic [COLOR_BITS-1:0] bg_color,
	input  logic [IDX_W-1:0]      pair_index,
	input  logic                  cfg_wr_en,
	input  logic [LIMIT_W-1:0]    cfg_wr_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [IDX_W-1:0]      result_index,
	input  logic [STAT_W-1:0]     status,
	input  logic [REF_W-1:0]      ref_count_out,
	input  logic                  first_overflow,
	input  logic [IDX_W-1:0]      pairs_in_use,
	output int                    outstanding,
	output int                    errors
);

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [STAT_W-1:0] stat;
		logic [REF_W-1:0]  refs;
		logic              ovf;
		logic [IDX_W-1:0]  in_use;
	} pair_result_t;

	// Shadow copy of the pair table
	bit                    slot_used [SLOTS];
	logic [COLOR_BITS-1:0] slot_fg   [SLOTS];
	logic [COLOR_BITS-1:0] slot_bg   [SLOTS];
	logic [REF_W-1:0]      slot_refs [SLOTS];
	int                    pairs_held;
	bit                    overflow_seen;
	logic [LIMIT_W-1:0]    limit;

	pair_result_t expected_results[$];
	int           shown = 0;

	initial begin
		errors      = 0;
		outstanding = 0;
	end

	// Print the first few mismatches, count them all
	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (shown < 60)
			$display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		shown++;
	endtask

	function automatic pair_result_t make_result(input int idx, input logic [STAT_W-1:0] st,
			input logic [REF_W-1:0] refs, input logic ovf);
		pair_result_t r;
		r.index  = IDX_W'(idx);
		r.stat   = st;
		r.refs   = refs;
		r.ovf    = ovf;
		r.in_use = IDX_W'(pairs_held);
		return r;
	endfunction

	// Apply one acquire or release to the shadow table and work out its result
	task automatic predict_pair_op(input logic cmd, input logic [COLOR_BITS-1:0] fg,
			input logic [COLOR_BITS-1:0] bg, input logic [IDX_W-1:0] idx,
			output pair_result_t res);
		int  hit;
		int  hole;
		int  s;
		logic ovf;
		hit  = -1;
		hole = -1;
		if (cmd == CMD_ACQUIRE) begin
			if (fg == '1 && bg == '1) begin
				res = make_result(0, STAT_BOTH_DEFAULT, '0, 1'b0);
			end else begin
				for (s = 0; s < SLOTS; s++) begin
					if (hit < 0 && slot_used[s] && slot_fg[s] == fg && slot_bg[s] == bg)
						hit = s;
					if (hole < 0 && !slot_used[s])
						hole = s;
				end
				if (hit >= 0) begin
					// share, count sticks at its maximum
					if (slot_refs[hit] != REF_MAX)
						slot_refs[hit]++;
					res = make_result(hit + FIRST_INDEX, STAT_SHARED, slot_refs[hit], 1'b0);
				end else if (hole < 0 || hole + FIRST_INDEX >= int'(limit)) begin
					// refuse; flag only the first refusal under a nonzero limit
					ovf = (limit != '0) && !overflow_seen;
					if (ovf)
						overflow_seen = 1'b1;
					res = make_result(0, STAT_FULL, '0, ovf);
				end else begin
					slot_used[hole] = 1'b1;
					slot_fg[hole]   = fg;
					slot_bg[hole]   = bg;
					slot_refs[hole] = 1;
					pairs_held++;
					res = make_result(hole + FIRST_INDEX, STAT_NEW, 1, 1'b0);
				end
			end
		end else begin
			s = int'(idx) - FIRST_INDEX;
			if (idx < FIRST_INDEX || idx >= MAX_PAIRS) begin
				res = make_result(0, STAT_IGNORED, '0, 1'b0);
			end else if (!slot_used[s]) begin
				res = make_result(0, STAT_IGNORED, '0, 1'b0);
			end else begin
				if (slot_refs[s] != '0)
					slot_refs[s]--;
				if (slot_refs[s] != '0) begin
					res = make_result(idx, STAT_STILL_USED, slot_refs[s], 1'b0);
				end else begin
					slot_used[s] = 1'b0;
					if (pairs_held > 0)
						pairs_held--;
					res = make_result(idx, STAT_FREED, '0, 1'b0);
				end
			end
		end
	endtask

	// Track config, predict accepted items, check accepted results
	always @(posedge clk or negedge arst_n) begin : watch
		pair_result_t res;
		pair_result_t want;
		if (!arst_n) begin
			slot_used     = '{default: 1'b0};
			pairs_held    = 0;
			overflow_seen = 1'b0;
			limit         = LIMIT_RESET;
			expected_results.delete();
		end else begin
			if (cfg_wr_en)
				limit = cfg_wr_data;
			if (in_valid && !in_stall) begin
				predict_pair_op(command, fg_color, bg_color, pair_index, res);
				expected_results.push_back(res);
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no item pending (index)", result_index, -1);
				end else begin
					want = expected_results.pop_front();
					if (result_index !== want.index)
						report_mismatch("result_index", result_index, want.index);
					if (status !== want.stat)
						report_mismatch("status", status, want.stat);
					if (ref_count_out !== want.refs)
						report_mismatch("ref_count_out", ref_count_out, want.refs);
					if (first_overflow !== want.ovf)
						report_mismatch("first_overflow", first_overflow, want.ovf);
					if (pairs_in_use !== want.in_use)
						report_mismatch("pairs_in_use", pairs_in_use, want.in_use);
				end
			end
		end
		outstanding = expected_results.size();
	end

endmodule

FILE: verif/refcounted_color_pair_allocator_tb.sv
// Stimulus, idling and verdict for the color pair allocator testbench.
`timescale 1ns / 1ps

module refcounted_color_pair_allocator_tb;
	import rcpa_pkg::*;

	localparam int QUIET_LIMIT = 8000;
	localparam int HOLD_CYCLES = 1500;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic                         command;
	logic signed [COLOR_BITS-1:0] fg_color;
	logic signed [COLOR_BITS-1:0] bg_color;
	logic [IDX_W-1:0]             pair_index;
	logic                         cfg_wr_en;
	logic [LIMIT_W-1:0]           cfg_wr_data;
	logic                         out_valid;
	logic                         out_stall;
	logic [IDX_W-1:0]             result_index;
	logic [STAT_W-1:0]            status;
	logic [REF_W-1:0]             ref_count_out;
	logic                         first_overflow;
	logic [IDX_W-1:0]             pairs_in_use;
	int                           outstanding;
	int                           errors;

	bit                           steady;
	int                           quiet;
	logic signed [COLOR_BITS-1:0] pool_fg [16];
	logic signed [COLOR_BITS-1:0] pool_bg [16];
	int                           pool_n;

	refcounted_color_pair_allocator dut (.*);
	color_pair_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic logic signed [COLOR_BITS-1:0] pick_color();
		case ($urandom_range(0, 3))
			0: return '1;
			1: return COLOR_BITS'($urandom_range(0, 15));
			2: return COLOR_BITS'($urandom_range(0, 16777215));
			default: return COLOR_BITS'($urandom());
		endcase
	endfunction

	// Offer one item after a random gap, return at the edge that takes it
	task automatic send_item(input logic cmd, input logic signed [COLOR_BITS-1:0] fg,
			input logic signed [COLOR_BITS-1:0] bg, input logic [IDX_W-1:0] idx);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		fg_color   <= fg;
		bg_color   <= bg;
		pair_index <= idx;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic take_pair(input logic signed [COLOR_BITS-1:0] fg,
			input logic signed [COLOR_BITS-1:0] bg);
		send_item(CMD_ACQUIRE, fg, bg, IDX_W'($urandom()));
	endtask

	task automatic drop_pair(input int idx);
		send_item(CMD_RELEASE, COLOR_BITS'($urandom()), COLOR_BITS'($urandom()), IDX_W'(idx));
	endtask

	// Hold input, wait until every pending result is out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_limit(input int value);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= LIMIT_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Mostly acquire and release over a small pool of pairs, some noise
	task automatic random_phase(input int value, input int count, input bit quiet_phase);
		int r;
		int k;
		set_limit(value);
		steady = quiet_phase;
		pool_n = $urandom_range(2, 12);
		for (k = 0; k < pool_n; k++) begin
			pool_fg[k] = pick_color();
			pool_bg[k] = pick_color();
		end
		repeat (count) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, pool_n - 1);
			if (r < 40)
				take_pair(pool_fg[k], pool_bg[k]);
			else if (r < 44)
				take_pair('1, '1);
			else if (r < 50)
				take_pair(COLOR_BITS'($urandom()), COLOR_BITS'($urandom()));
			else if (r < 88)
				drop_pair(FIRST_INDEX + $urandom_range(0, pool_n + 3));
			else if (r < 94)
				drop_pair($urandom_range(0, FIRST_INDEX - 1));
			else
				drop_pair($urandom_range(0, 255));
		end
		steady = 1'b0;
	endtask

	// Result side: random stall per item, two long hold-offs to back up the input
	initial begin : result_side
		int taken;
		int hold;
		taken = 0;
		out_stall <= 1'b0;
		wait (arst_n);
		forever begin
			hold = (taken == 100 || taken == 900) ? HOLD_CYCLES : draw_wait();
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int limits[8];
		int i;
		steady      = 1'b0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		command     <= CMD_ACQUIRE;
		fg_color    <= '0;
		bg_color    <= '0;
		pair_index  <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: defaults, sharing, ignored releases, free and reuse at reset limit
		take_pair('1, '1);
		take_pair('1, 0);
		take_pair(0, '1);
		take_pair('1, 0);
		take_pair(16777215, 16777215);
		drop_pair(0);
		drop_pair(FIRST_INDEX - 1);
		drop_pair(255);
		drop_pair(FIRST_INDEX);
		drop_pair(FIRST_INDEX);
		take_pair(5, 6);
		drop_pair(FIRST_INDEX);
		drop_pair(FIRST_INDEX + 1);
		drop_pair(FIRST_INDEX + 2);

		// Zero limit refuses without raising the overflow flag
		set_limit(0);
		take_pair(1, 2);
		take_pair('1, '1);
		drop_pair(FIRST_INDEX);

		// Room for one pair: first refusal flags, later ones do not
		set_limit(FIRST_INDEX + 1);
		take_pair(1, 2);
		take_pair(3, 4);
		take_pair(5, 6);
		take_pair(1, 2);
		drop_pair(FIRST_INDEX);
		drop_pair(FIRST_INDEX);

		// Fill every slot, then use the top entry under a lowered limit
		set_limit(256);
		for (i = 0; i < SLOTS; i++)
			take_pair(COLOR_BITS'(1000 + i), COLOR_BITS'(i));
		take_pair(7, 7);
		set_limit(32);
		take_pair(COLOR_BITS'(1000 + SLOTS - 1), COLOR_BITS'(SLOTS - 1));
		drop_pair(MAX_PAIRS - 1);
		drop_pair(MAX_PAIRS - 1);
		take_pair(7, 7);
		for (i = FIRST_INDEX; i < MAX_PAIRS - 1; i++)
			drop_pair(i);

		// Random phases over a spread of limits, one phase with no idling
		limits = '{256, 20, 0, 16, 17, 255, 1, 0};
		limits[7] = $urandom_range(0, 256);
		for (i = 0; i < 8; i++)
			random_phase(limits[i], 145, i == 0);

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
